@@ sv/ifpg_pkg.sv @@
// ----------------------------------------------------------------------------
// ifpg_pkg: shared types, constants and functions of the fern point generator
// Holds the fixed-point format, the map coefficients, the controller to
// datapath command and status structs, and the fixed-point product.
// ----------------------------------------------------------------------------
package ifpg_pkg;

    // Fixed-point format of the stored point.
    localparam int FRAC_BITS   = 24;
    localparam int POINT_W     = 32;
    localparam int SCREEN_ROWS = 64;
    localparam int COORD_W     = 8;
    localparam int SEL_W       = 8;

    localparam logic [COORD_W-1:0] ROW_OFFSET = COORD_W'(SCREEN_ROWS / 2);

    // Selector thresholds between the four maps.
    localparam logic [SEL_W-1:0] SEL_STEM_LIMIT = 8'd2;
    localparam logic [SEL_W-1:0] SEL_MAIN_LIMIT = 8'd219;
    localparam logic [SEL_W-1:0] SEL_LEFT_LIMIT = 8'd237;

    // One in fixed point; constants are truncated toward zero, then negated.
    localparam longint unsigned FX_ONE = 64'd1 << FRAC_BITS;

    localparam logic signed [POINT_W-1:0] K_0P85 = POINT_W'((FX_ONE * 85) / 100);
    localparam logic signed [POINT_W-1:0] K_0P04 = POINT_W'((FX_ONE * 4) / 100);
    localparam logic signed [POINT_W-1:0] K_1P60 = POINT_W'((FX_ONE * 160) / 100);
    localparam logic signed [POINT_W-1:0] K_0P16 = POINT_W'((FX_ONE * 16) / 100);
    localparam logic signed [POINT_W-1:0] K_0P20 = POINT_W'((FX_ONE * 20) / 100);
    localparam logic signed [POINT_W-1:0] K_0P26 = POINT_W'((FX_ONE * 26) / 100);
    localparam logic signed [POINT_W-1:0] K_0P23 = POINT_W'((FX_ONE * 23) / 100);
    localparam logic signed [POINT_W-1:0] K_0P22 = POINT_W'((FX_ONE * 22) / 100);
    localparam logic signed [POINT_W-1:0] K_0P15 = POINT_W'((FX_ONE * 15) / 100);
    localparam logic signed [POINT_W-1:0] K_0P28 = POINT_W'((FX_ONE * 28) / 100);
    localparam logic signed [POINT_W-1:0] K_0P24 = POINT_W'((FX_ONE * 24) / 100);
    localparam logic signed [POINT_W-1:0] K_0P44 = POINT_W'((FX_ONE * 44) / 100);
    localparam logic signed [POINT_W-1:0] K_COL  = POINT_W'((FX_ONE * 96) / 10);
    localparam logic signed [POINT_W-1:0] K_ROW  = POINT_W'((FX_ONE * 128) / 10);

    // Coefficients of one affine map:
    // x' = kxx*x + kxy*y, y' = kyx*x + kyy*y + ofs.
    typedef struct packed {
        logic signed [POINT_W-1:0] kxx;
        logic signed [POINT_W-1:0] kxy;
        logic signed [POINT_W-1:0] kyx;
        logic signed [POINT_W-1:0] kyy;
        logic signed [POINT_W-1:0] ofs;
    } map_coef_t;

    // Which coefficient pair feeds the two multipliers.
    typedef enum logic [1:0] {
        COEF_MAP_X = 2'd0,
        COEF_MAP_Y = 2'd1,
        COEF_SCALE = 2'd2
    } coef_sel_t;

    typedef struct packed {
        logic      load_sel;   // capture the incoming selector byte
        logic      mul_en;     // register both products
        coef_sel_t coef_sel;   // coefficient pair for the multipliers
        logic      save_nx;    // hold the new x until y has been formed
        logic      upd_point;  // write the new point
        logic      load_out;   // move the scaled point into the output register
    } dp_cmd_t;

    typedef struct packed {
        logic out_stall;       // output register full and not being taken
    } dp_status_t;

    function automatic map_coef_t map_coef(input logic [SEL_W-1:0] sel);
        map_coef_t c;
        if (sel < SEL_STEM_LIMIT) begin
            c = '{kxx: '0, kxy: '0, kyx: '0, kyy: K_0P16, ofs: '0};
        end else if (sel < SEL_MAIN_LIMIT) begin
            c = '{kxx: K_0P85, kxy: K_0P04, kyx: -K_0P04, kyy: K_0P85, ofs: K_1P60};
        end else if (sel < SEL_LEFT_LIMIT) begin
            c = '{kxx: K_0P20, kxy: -K_0P26, kyx: K_0P23, kyy: K_0P22, ofs: K_1P60};
        end else begin
            c = '{kxx: -K_0P15, kxy: K_0P28, kyx: K_0P26, kyy: K_0P24, ofs: K_0P44};
        end
        return c;
    endfunction

    // Fixed-point product: full product, floor shift, low word kept.
    function automatic logic signed [POINT_W-1:0] fmul(
        input logic signed [POINT_W-1:0] k,
        input logic signed [POINT_W-1:0] a
    );
        logic signed [2*POINT_W-1:0] p;
        p = k * a;
        return POINT_W'(p >>> FRAC_BITS);
    endfunction

endpackage

@@ sv/ifs_fern_point_generator_top.sv @@
// ----------------------------------------------------------------------------
// ifs_fern_point_generator_top: Barnsley fern point generator
// An accepted item goes through the map, point update and scaling steps;
// its point shows on m_tdata after the emit state, or later if the previous
// point is still waiting there. The block takes no new item until the
// sequencer has walked the two shared multipliers through those steps.
// The output register lets the next item start while a point waits.
// Reset (aresetn low, synchronous) clears the point to the origin and
// empties the output register.
// ----------------------------------------------------------------------------
module ifs_fern_point_generator_top (
    input  logic        aclk,
    input  logic        aresetn,
    // Input items: one random byte each.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] random_byte
    // Result items: one screen point per input item.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata      // [7:0] column, [15:8] row
);

    // The controller steps each item through its phases. The datapath holds
    // the point, two multipliers (one fed by x and one by y) and the output
    // register. Both multipliers are reused three times per item: for the
    // new x terms, for the new y terms, and for the screen scaling.
    ifpg_pkg::dp_cmd_t    cmd;
    ifpg_pkg::dp_status_t status;

    logic signed [ifpg_pkg::COORD_W-1:0] column;
    logic signed [ifpg_pkg::COORD_W-1:0] row;

    ifpg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ifpg_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .random_byte (s_tdata),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .column      (column),
        .row         (row)
    );

    // Coordinates are raw two's complement; wrap-around is left for the
    // display to clip.
    assign m_tdata = {row, column};

endmodule

@@ sv/ifpg_ctrl.sv @@
// ----------------------------------------------------------------------------
// ifpg_ctrl: sequencer of the fern point generator
// Steps one item through map products, point update, scaling and output.
// ----------------------------------------------------------------------------
module ifpg_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  ifpg_pkg::dp_status_t status,
    output ifpg_pkg::dp_cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MAP_X = 6'b000010,
        ST_MAP_Y = 6'b000100,
        ST_SUM_Y = 6'b001000,
        ST_SCALE = 6'b010000,
        ST_EMIT  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '{coef_sel: ifpg_pkg::COEF_MAP_X, default: 1'b0};
        case (state_reg)
            ST_IDLE: begin
                s_tready     = 1'b1;
                cmd.load_sel = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_MAP_X;
                end
            end
            ST_MAP_X: begin
                cmd.mul_en   = 1'b1;
                cmd.coef_sel = ifpg_pkg::COEF_MAP_X;
                state_next   = ST_MAP_Y;
            end
            ST_MAP_Y: begin
                cmd.mul_en   = 1'b1;
                cmd.coef_sel = ifpg_pkg::COEF_MAP_Y;
                cmd.save_nx  = 1'b1;
                state_next   = ST_SUM_Y;
            end
            ST_SUM_Y: begin
                cmd.upd_point = 1'b1;
                state_next    = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.mul_en   = 1'b1;
                cmd.coef_sel = ifpg_pkg::COEF_SCALE;
                state_next   = ST_EMIT;
            end
            ST_EMIT: begin
                if (!status.out_stall) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ sv/ifpg_datapath.sv @@
// ----------------------------------------------------------------------------
// ifpg_datapath: point registers, two multipliers and output register
// One multiplier always takes x and the other y; the coefficients change.
// ----------------------------------------------------------------------------
module ifpg_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  ifpg_pkg::dp_cmd_t                    cmd,
    output ifpg_pkg::dp_status_t                 status,
    input  logic [ifpg_pkg::SEL_W-1:0]           random_byte,
    input  logic                                 m_tready,
    output logic                                 m_tvalid,
    output logic signed [ifpg_pkg::COORD_W-1:0]  column,
    output logic signed [ifpg_pkg::COORD_W-1:0]  row
);

    logic [ifpg_pkg::SEL_W-1:0]            sel_reg;
    logic signed [ifpg_pkg::POINT_W-1:0]   point_x_reg;
    logic signed [ifpg_pkg::POINT_W-1:0]   point_y_reg;
    logic signed [ifpg_pkg::POINT_W-1:0]   nx_reg;
    logic signed [ifpg_pkg::POINT_W-1:0]   prod_x_reg;
    logic signed [ifpg_pkg::POINT_W-1:0]   prod_y_reg;
    logic                                  out_valid_reg;
    logic                                  out_valid_next;
    logic signed [ifpg_pkg::COORD_W-1:0]   column_reg;
    logic signed [ifpg_pkg::COORD_W-1:0]   row_reg;

    ifpg_pkg::map_coef_t                   coef;
    logic signed [ifpg_pkg::POINT_W-1:0]   k_x;
    logic signed [ifpg_pkg::POINT_W-1:0]   k_y;
    logic signed [ifpg_pkg::POINT_W-1:0]   prod_sum;

    assign coef     = ifpg_pkg::map_coef(sel_reg);
    assign prod_sum = prod_x_reg + prod_y_reg;

    always_comb begin
        case (cmd.coef_sel)
            ifpg_pkg::COEF_MAP_X: begin
                k_x = coef.kxx;
                k_y = coef.kxy;
            end
            ifpg_pkg::COEF_MAP_Y: begin
                k_x = coef.kyx;
                k_y = coef.kyy;
            end
            ifpg_pkg::COEF_SCALE: begin
                k_x = ifpg_pkg::K_ROW;
                k_y = ifpg_pkg::K_COL;
            end
            default: begin
                k_x = '0;
                k_y = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_sel) begin
            sel_reg <= random_byte;
        end
        if (cmd.mul_en) begin
            prod_x_reg <= ifpg_pkg::fmul(k_x, point_x_reg);
            prod_y_reg <= ifpg_pkg::fmul(k_y, point_y_reg);
        end
        if (cmd.save_nx) begin
            nx_reg <= prod_sum;
        end
        if (cmd.load_out) begin
            column_reg <= ifpg_pkg::COORD_W'(prod_y_reg >>> ifpg_pkg::FRAC_BITS);
            row_reg    <= ifpg_pkg::COORD_W'(prod_x_reg >>> ifpg_pkg::FRAC_BITS)
                          + ifpg_pkg::ROW_OFFSET;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_x_reg <= '0;
            point_y_reg <= '0;
        end else if (cmd.upd_point) begin
            point_x_reg <= nx_reg;
            point_y_reg <= prod_sum + coef.ofs;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign status.out_stall = out_valid_reg && !m_tready;
    assign m_tvalid         = out_valid_reg;
    assign column           = column_reg;
    assign row              = row_reg;

endmodule

@@ sv/ifpg_checker.sv @@
// ----------------------------------------------------------------------------
// ifpg_checker: port-level checks of the fern point generator
// Watches the two streams and is attached to the top level by a bind.
// ----------------------------------------------------------------------------
module ifpg_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata
);

    logic s_acc;
    assign s_acc = s_tvalid && s_tready;

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A waiting result holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("waiting result changed or dropped");

    // One item at a time: input is refused while the item's map products are formed.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> !s_tready ##1 !s_tready)
        else $error("input accepted while an item was in progress");

    // A new result only appears at the end of an item's work.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared while the block was idle");

    // An offered item carries a known selector byte.
    a_data_known: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid |-> !$isunknown(s_tdata))
        else $error("input item offered with unknown data");

endmodule

bind ifs_fern_point_generator_top ifpg_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
